// ===== hdl/ghe_pkg.sv =====
// Shared types and constants for the geohash encoder core.
// No dependencies; every other file in hdl/ imports this package.
package ghe_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int LAT_W      = 36;
    localparam int LNG_W      = 37;
    localparam int LEN_W      = 4;
    localparam int MAX_CHARS  = 12;
    localparam int IN_TDATA_W = ((LAT_W + LNG_W + 7) / 8) * 8;
    localparam int CHAR_W     = 7;
    localparam int OUT_TDATA_W = 8;

    // Coordinate limits in fixed point.
    localparam logic signed [LAT_W-1:0] LAT_LIMIT = LAT_W'(64'd90 << FRAC_BITS);
    localparam logic signed [LNG_W-1:0] LNG_LIMIT = LNG_W'(64'd180 << FRAC_BITS);

    // Half of the full interval width; the first bisection compares against this.
    localparam logic [LAT_W-1:0] LAT_HALF0 = LAT_W'(64'd90 << FRAC_BITS);
    localparam logic [LNG_W-1:0] LNG_HALF0 = LNG_W'(64'd180 << FRAC_BITS);

    localparam logic [CHAR_W-1:0] OOR_CHAR = 7'd48;

    localparam logic [CHAR_W-1:0] ALPHABET [32] = '{
        7'd48, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55,
        7'd56, 7'd57, 7'd98, 7'd99, 7'd100, 7'd101, 7'd102, 7'd103,
        7'd104, 7'd106, 7'd107, 7'd109, 7'd110, 7'd112, 7'd113, 7'd114,
        7'd115, 7'd116, 7'd117, 7'd118, 7'd119, 7'd120, 7'd121, 7'd122
    };

    // One classified coordinate: offsets from the lower interval bounds.
    typedef struct packed {
        logic [LAT_W-1:0] lat_ofs;
        logic [LNG_W-1:0] lng_ofs;
        logic             oor;
        logic [LEN_W-1:0] len;
    } t_job;

endpackage

// ===== hdl/ghe_front.sv =====
// Front end: range check, length clamp and offset computation per coordinate.
// Depends on ghe_pkg.
module ghe_front (
    input  logic signed [ghe_pkg::LAT_W-1:0] i_lat,
    input  logic signed [ghe_pkg::LNG_W-1:0] i_lng,
    input  logic [ghe_pkg::LEN_W-1:0]        i_len_cfg,
    output ghe_pkg::t_job                    o_job
);
    import ghe_pkg::*;

    logic                    lat_bad;
    logic                    lng_bad;
    logic signed [LAT_W:0]   lat_sum;
    logic signed [LNG_W:0]   lng_sum;
    logic [LEN_W-1:0]        len;

    assign lat_bad = (i_lat < -LAT_LIMIT) || (i_lat > LAT_LIMIT);
    assign lng_bad = (i_lng < -LNG_LIMIT) || (i_lng > LNG_LIMIT);

    // For a valid coordinate the offset lies in [0, full width] and fits unsigned.
    assign lat_sum = (LAT_W+1)'(i_lat) + (LAT_W+1)'(LAT_LIMIT);
    assign lng_sum = (LNG_W+1)'(i_lng) + (LNG_W+1)'(LNG_LIMIT);

    always_comb begin
        priority if (i_len_cfg == '0) begin
            len = LEN_W'(1);
        end else if (i_len_cfg > LEN_W'(MAX_CHARS)) begin
            len = LEN_W'(MAX_CHARS);
        end else begin
            len = i_len_cfg;
        end
    end

    assign o_job.lat_ofs = lat_sum[LAT_W-1:0];
    assign o_job.lng_ofs = lng_sum[LNG_W-1:0];
    assign o_job.oor     = lat_bad | lng_bad;
    assign o_job.len     = len;

endmodule

// ===== hdl/ghe_queue.sv =====
// Two-entry queue of classified coordinates between front and back end.
// Depends on ghe_pkg.
module ghe_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ghe_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output ghe_pkg::t_job o_job,
    output logic          o_empty
);
    import ghe_pkg::*;

    t_job       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

// ===== hdl/ghe_back.sv =====
// Back end: five interleaved bisection steps per cycle, one character out per cycle
// unless the output stalls, held in an output register. Depends on ghe_pkg.
module ghe_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_job_avail,
    input  ghe_pkg::t_job                 i_job,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ghe_pkg::CHAR_W-1:0]    o_char,
    output logic                          o_last,
    output logic                          o_oor
);
    import ghe_pkg::*;

    logic                r_busy;
    logic [LAT_W-1:0]    r_lat_r;
    logic [LNG_W-1:0]    r_lng_r;
    logic [LAT_W-1:0]    r_lat_half;
    logic [LNG_W-1:0]    r_lng_half;
    logic                r_lng_turn;
    logic [LEN_W-1:0]    r_left;
    logic                r_oor;
    logic                r_valid;
    logic [CHAR_W-1:0]   r_char;
    logic                r_last;
    logic                r_oor_out;

    logic [LAT_W-1:0]    n_lat_r;
    logic [LNG_W-1:0]    n_lng_r;
    logic [LAT_W-1:0]    n_lat_half;
    logic [LNG_W-1:0]    n_lng_half;
    logic [4:0]          n_code;
    logic                emit;
    logic                final_char;

    // The remainder tracks coordinate minus lower bound; the half width shrinks
    // by one bit per step of that coordinate and stays exact over all steps.
    always_comb begin
        logic turn;
        logic b;
        n_lat_r    = r_lat_r;
        n_lng_r    = r_lng_r;
        n_lat_half = r_lat_half;
        n_lng_half = r_lng_half;
        n_code     = '0;
        turn       = r_lng_turn;
        for (int i = 0; i < 5; i++) begin
            if (turn) begin
                b = (n_lng_r > n_lng_half);
                if (b) begin
                    n_lng_r = n_lng_r - n_lng_half;
                end
                n_lng_half = n_lng_half >> 1;
            end else begin
                b = (n_lat_r > n_lat_half);
                if (b) begin
                    n_lat_r = n_lat_r - n_lat_half;
                end
                n_lat_half = n_lat_half >> 1;
            end
            n_code = {n_code[3:0], b};
            turn   = ~turn;
        end
    end

    assign emit       = r_busy && (!r_valid || i_ready);
    assign final_char = r_oor || (r_left == LEN_W'(1));
    assign o_pop      = !r_busy && i_job_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (emit && final_char) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_lat_r    <= i_job.lat_ofs;
            r_lng_r    <= i_job.lng_ofs;
            r_lat_half <= LAT_HALF0;
            r_lng_half <= LNG_HALF0;
            r_lng_turn <= 1'b1;
            r_left     <= i_job.len;
            r_oor      <= i_job.oor;
        end else if (emit) begin
            r_lat_r    <= n_lat_r;
            r_lng_r    <= n_lng_r;
            r_lat_half <= n_lat_half;
            r_lng_half <= n_lng_half;
            r_lng_turn <= ~r_lng_turn;
            r_left     <= r_left - LEN_W'(1);
        end
        if (emit) begin
            r_char    <= r_oor ? OOR_CHAR : ALPHABET[n_code];
            r_last    <= final_char;
            r_oor_out <= r_oor;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;
    assign o_oor   = r_oor_out;

endmodule

// ===== hdl/geohash_encoder_core.sv =====
// Top level of the geohash encoder: stream ports, length register and the
// front end, queue and back end. Depends on ghe_pkg, ghe_front, ghe_queue, ghe_back.
//
// A coordinate pair accepted on the slave stream is range checked at once and
// queued (two entries). The back end takes one entry per coordinate, only once it
// has finished the previous one, then produces one character per cycle unless the
// output stalls, five bisection steps each. The final character carries tlast,
// and tuser marks a coordinate out of range, which gives a single '0' result.
// hash_length 0 acts as 1 and values above 12 act as 12; the length is sampled
// when a coordinate is accepted.
module geohash_encoder_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ghe_pkg::LEN_W-1:0]          i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // latitude [35:0], longitude [72:36], zero fill [79:73]
    input  logic [ghe_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // hash_char [6:0], zero fill [7]
    output logic [ghe_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast,
    // out_of_range [0]
    output logic                               m_axis_tuser
);
    import ghe_pkg::*;

    logic [LEN_W-1:0]  r_hash_length;
    t_job              front_job;
    t_job              queue_job;
    logic              q_full;
    logic              q_empty;
    logic              pop;
    logic [CHAR_W-1:0] out_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_length <= LEN_W'(MAX_CHARS);
        end else if (i_cfg_we) begin
            r_hash_length <= i_cfg_wdata;
        end
    end

    ghe_front u_front (
        .i_lat     (s_axis_tdata[LAT_W-1:0]),
        .i_lng     (s_axis_tdata[LAT_W+LNG_W-1:LAT_W]),
        .i_len_cfg (r_hash_length),
        .o_job     (front_job)
    );

    assign s_axis_tready = !q_full;

    ghe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_empty (q_empty)
    );

    ghe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_avail (!q_empty),
        .i_job       (queue_job),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_char      (out_char),
        .o_last      (m_axis_tlast),
        .o_oor       (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, out_char};

endmodule

// ===== hdl/ghe_checker.sv =====
// Port-level checks on the result stream of geohash_encoder_core, bound to it.
// Depends on ghe_pkg.
module ghe_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [ghe_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic                             m_axis_tlast,
    input logic                             m_axis_tuser
);
    import ghe_pkg::*;

    // No result may appear in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // An out-of-range coordinate yields one closing '0' result.
    a_oor_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tlast && (m_axis_tdata == {1'b0, OOR_CHAR}))
        else $error("out-of-range result malformed");

    // A stalled result holds its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Every character lies in the base32 alphabet's ASCII span.
    a_char_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata >= 8'd48) && (m_axis_tdata <= 8'd122))
        else $error("character outside alphabet span");

endmodule

bind geohash_encoder_core ghe_checker u_ghe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== dv/geohash_checker.sv =====
// Scoreboard for geohash_encoder_core: watches the length register, the coordinate
// stream and the character stream, predicts every character and compares.
// Depends on ghe_pkg for widths and limits.
`timescale 1ns / 1ps

module geohash_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ghe_pkg::LEN_W-1:0]       i_cfg_wdata,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [ghe_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [ghe_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                            i_m_tlast,
    input  logic                            i_m_tuser,
    output int                              o_mismatches,
    output int                              o_chars_pending
);
    import ghe_pkg::*;

    localparam string  GLYPHS   = "0123456789bcdefghjkmnpqrstuvwxyz";
    localparam longint LAT_SPAN = longint'(90) <<< FRAC_BITS;
    localparam longint LNG_SPAN = longint'(180) <<< FRAC_BITS;

    typedef struct packed {
        logic [CHAR_W-1:0] glyph;
        logic              last;
        logic              oor;
    } t_hash_char;

    t_hash_char       expected_chars[$];
    logic [LEN_W-1:0] hash_length;
    int               mismatches = 0;

    task automatic report_mismatch(input string msg);
        if (mismatches < 100)
            $display("%0t ns  ERROR  %s", $realtime, msg);
        mismatches++;
    endtask

    // Queues the characters of one coordinate pair under the current length.
    task automatic predict_geohash(input longint lat, input longint lng);
        longint     lat_lo;
        longint     lat_hi;
        longint     lng_lo;
        longint     lng_hi;
        longint     mid;
        int         n_chars;
        logic [4:0] code;
        bit         on_lng;
        bit         upper;
        t_hash_char c;
        if (lat < -LAT_SPAN || lat > LAT_SPAN || lng < -LNG_SPAN || lng > LNG_SPAN) begin
            c.glyph = CHAR_W'(GLYPHS[0]);
            c.last  = 1'b1;
            c.oor   = 1'b1;
            expected_chars.push_back(c);
            return;
        end
        n_chars = (hash_length == 0) ? 1 : (hash_length > MAX_CHARS) ? MAX_CHARS : hash_length;
        lat_lo = -LAT_SPAN;
        lat_hi = LAT_SPAN;
        lng_lo = -LNG_SPAN;
        lng_hi = LNG_SPAN;
        on_lng = 1'b1;
        for (int k = 0; k < n_chars; k++) begin
            code = '0;
            for (int b = 0; b < 5; b++) begin
                // A coordinate exactly on the midpoint falls into the lower half.
                if (on_lng) begin
                    mid   = lng_lo + (lng_hi - lng_lo) / 2;
                    upper = lng > mid;
                    if (upper) lng_lo = mid;
                    else       lng_hi = mid;
                end else begin
                    mid   = lat_lo + (lat_hi - lat_lo) / 2;
                    upper = lat > mid;
                    if (upper) lat_lo = mid;
                    else       lat_hi = mid;
                end
                code   = {code[3:0], upper};
                on_lng = !on_lng;
            end
            c.glyph = CHAR_W'(GLYPHS[code]);
            c.last  = (k == n_chars - 1);
            c.oor   = 1'b0;
            expected_chars.push_back(c);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_hash_char got;
        t_hash_char want;
        if (!i_rst_n) begin
            hash_length = LEN_W'(MAX_CHARS);
            expected_chars.delete();
        end else begin
            if (i_cfg_we)
                hash_length = i_cfg_wdata;
            if (i_s_tvalid && i_s_tready)
                predict_geohash(longint'($signed(i_s_tdata[LAT_W-1:0])),
                                longint'($signed(i_s_tdata[LAT_W+LNG_W-1:LAT_W])));
            if (i_m_tvalid && i_m_tready) begin
                got.glyph = i_m_tdata[CHAR_W-1:0];
                got.last  = i_m_tlast;
                got.oor   = i_m_tuser;
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("character 0x%0h arrived with none expected",
                                              got.glyph));
                end else begin
                    want = expected_chars.pop_front();
                    if (got.glyph !== want.glyph)
                        report_mismatch($sformatf("hash_char 0x%0h, expected 0x%0h",
                                                  got.glyph, want.glyph));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last_char %b, expected %b",
                                                  got.last, want.last));
                    if (got.oor !== want.oor)
                        report_mismatch($sformatf("out_of_range %b, expected %b",
                                                  got.oor, want.oor));
                end
            end
        end
        o_mismatches    <= mismatches;
        o_chars_pending <= expected_chars.size();
    end

endmodule

// ===== dv/tb_geohash_encoder_core.sv =====
// Testbench top for geohash_encoder_core: clock, reset, length writes, coordinate
// stimulus and receiver back-pressure. Depends on ghe_pkg and geohash_checker.
`timescale 1ns / 1ps

module tb_geohash_encoder_core;
    import ghe_pkg::*;

    localparam longint LAT_MAX = longint'(90) <<< FRAC_BITS;
    localparam longint LNG_MAX = longint'(180) <<< FRAC_BITS;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [LEN_W-1:0]       i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   m_axis_tuser;

    int mismatches;
    int chars_pending;
    bit tx_gaps   = 1'b0;
    bit rx_stalls = 1'b0;
    int rx_hold   = 0;

    logic [LEN_W-1:0] phase_len [9] = '{4'd1, 4'd0, 4'd15, 4'd7, 4'd3, 4'd12, 4'd9, 4'd2, 4'd13};

    geohash_encoder_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    geohash_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_tvalid      (s_axis_tvalid),
        .i_s_tready      (s_axis_tready),
        .i_s_tdata       (s_axis_tdata),
        .i_m_tvalid      (m_axis_tvalid),
        .i_m_tready      (m_axis_tready),
        .i_m_tdata       (m_axis_tdata),
        .i_m_tlast       (m_axis_tlast),
        .i_m_tuser       (m_axis_tuser),
        .o_mismatches    (mismatches),
        .o_chars_pending (chars_pending)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    // Mostly short pauses, now and then a long one.
    function automatic int gap_cycles();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 93) return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    // Mostly valid coordinates: uniform, on exact bisection grid points, or on or just
    // past the range edges; a few raw values that are usually out of range.
    function automatic longint pick_coord(input longint limit);
        logic [63:0] raw;
        int          r;
        int          s;
        raw = {$urandom, $urandom};
        r   = $urandom_range(99);
        if (r < 70) return longint'(raw % (2 * limit + 1)) - limit;
        if (r < 82) begin
            s = $urandom_range(1, 30);
            return -limit + ((2 * limit) >>> s) * longint'(raw % ((64'd1 << s) + 1));
        end
        if (r < 93) begin
            case ($urandom_range(3))
                0:       return limit;
                1:       return -limit;
                2:       return limit + 1;
                default: return -limit - 1;
            endcase
        end
        return longint'(raw);
    endfunction

    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else if (rx_stalls && $urandom_range(99) < 25) begin
            rx_hold = gap_cycles() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // tvalid is lowered only ahead of a pause, so back-to-back transfers keep it high.
    task automatic send_coord(input logic [LAT_W-1:0] lat, input logic [LNG_W-1:0] lng);
        int gap;
        gap = (tx_gaps && $urandom_range(99) < 35) ? gap_cycles() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {{(IN_TDATA_W - LAT_W - LNG_W){1'b0}}, lng, lat};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (chars_pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_length(input logic [LEN_W-1:0] len);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed coordinates under the reset length.
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        send_coord('0, '0);
        send_coord(LAT_W'(LAT_MAX), LNG_W'(LNG_MAX));
        send_coord(LAT_W'(-LAT_MAX), LNG_W'(-LNG_MAX));
        send_coord(LAT_W'(LAT_MAX), LNG_W'(-LNG_MAX));
        send_coord(LAT_W'(-LAT_MAX), LNG_W'(LNG_MAX));
        send_coord(LAT_W'(LAT_MAX + 1), '0);
        send_coord(LAT_W'(-LAT_MAX - 1), '0);
        send_coord('0, LNG_W'(LNG_MAX + 1));
        send_coord('0, LNG_W'(-LNG_MAX - 1));
        send_coord({1'b0, {(LAT_W - 1){1'b1}}}, {1'b0, {(LNG_W - 1){1'b1}}});
        send_coord({1'b1, {(LAT_W - 1){1'b0}}}, {1'b1, {(LNG_W - 1){1'b0}}});
        send_coord('1, '1);
        send_coord(LAT_W'(1), LNG_W'(1));
        send_coord(LAT_W'(LAT_MAX / 2), LNG_W'(-LNG_MAX / 2));

        // Shortest, zero, oversized and just-over-maximum lengths.
        set_length(4'd1);
        send_coord(LAT_W'(LAT_MAX), LNG_W'(LNG_MAX));
        send_coord(LAT_W'(LAT_MAX + 1), '0);
        set_length(4'd0);
        send_coord(LAT_W'(-1), LNG_W'(1));
        send_coord('0, LNG_W'(-LNG_MAX - 1));
        set_length(4'd15);
        send_coord(LAT_W'(-LAT_MAX), LNG_W'(LNG_MAX));
        send_coord('1, '1);
        set_length(4'd13);
        send_coord(LAT_W'(LAT_MAX / 3), LNG_W'(LNG_MAX / 7));

        for (int p = 0; p < 9; p++) begin
            set_length(p == 8 ? LEN_W'($urandom_range(15)) : phase_len[p]);
            tx_gaps   = (p != 0) && ($urandom_range(3) != 0);
            rx_stalls = (p != 0) && ($urandom_range(3) != 0);
            repeat (40)
                send_coord(LAT_W'(pick_coord(LAT_MAX)), LNG_W'(pick_coord(LNG_MAX)));
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ghe_pkg.sv
hdl/ghe_front.sv
hdl/ghe_queue.sv
hdl/ghe_back.sv
hdl/geohash_encoder_core.sv
hdl/ghe_checker.sv
dv/geohash_checker.sv
dv/tb_geohash_encoder_core.sv
